### sv/lpfr_pkg.sv
// Shared types and constants for the LRU page frame replacer.
`timescale 1ns / 1ps
package lpfr_pkg;

  localparam int unsigned PortPageW = 16;
  localparam int unsigned PortSlotW = 4;
  localparam int unsigned CfgW      = 5;
  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic lookup;  // compare stored page against the request
    logic update;  // apply the move-to-front shift
    logic miss;    // miss: every cell takes its neighbor's entry
  } lpfr_ctl_t;

endpackage

### sv/lru_page_frame_replacer_unit.sv
// LRU page frame replacer: move-to-front chain of cells, position 0 most recent.
// A word accepted in idle passes the lookup and update states; update waits for a free output register.
// Words are taken one at a time: accept, compare pass, then shift pass of the chain.
// While a result waits to be taken, the next word can be compared but its shift pass waits.
// Reset: async active low; no frames filled, cfg_q = 16, no page storage cleared.
`timescale 1ns / 1ps
module lru_page_frame_replacer_unit
  import lpfr_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PortPageW-1:0] page_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic [PortSlotW-1:0] slot_o,
  output logic                 evicted_valid_o,
  output logic [PortPageW-1:0] evicted_page_o
);

  localparam int unsigned SlotW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned ExtW  = (PAGE_BITS > PortPageW) ? PAGE_BITS : PortPageW;
  localparam int unsigned SlotExtW = (SlotW > PortSlotW) ? SlotW : PortSlotW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      filled_q;
  logic [CfgW-1:0]      cfg_q;
  logic [PAGE_BITS-1:0] req_page_q;

  lpfr_ctl_t            ctl;
  logic [PAGE_BITS-1:0] chain_page [MAX_FRAMES+1];
  logic [SlotW-1:0]     chain_slot [MAX_FRAMES+1];
  logic [MAX_FRAMES:0]  shift_chain;
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] filled_vec;

  logic [6:0]           cfg_ext;
  logic [6:0]           usable;
  logic                 can_fill;
  logic                 hit_w;
  logic [SlotW-1:0]     hit_slot;
  logic [SlotW-1:0]     new_slot;
  logic [PAGE_BITS-1:0] victim_page;
  logic                 out_free;
  logic                 advance;
  logic [ExtW-1:0]      page_ext;
  logic [ExtW-1:0]      evict_ext;
  logic [SlotExtW-1:0]  slot_ext;

  assign page_ext = ExtW'(page_i);

  // frame count clamped to 1..MAX_FRAMES
  assign cfg_ext = 7'(cfg_q);
  always_comb begin
    usable = cfg_ext;
    if (cfg_ext == 7'd0) begin
      usable = 7'd1;
    end else if (cfg_ext > 7'(MAX_FRAMES)) begin
      usable = 7'(MAX_FRAMES);
    end
  end
  assign can_fill = (7'(filled_q) < usable) && (7'(filled_q) < 7'(MAX_FRAMES));

  assign hit_w = |match_vec;

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      hit_slot = hit_slot | (chain_slot[i+1] & {SlotW{match_vec[i]}});
    end
  end

  // least recent entry sits at the last filled position
  assign victim_page = chain_page[filled_q];

  always_comb begin
    priority if (hit_w) begin
      new_slot = hit_slot;
    end else if (can_fill) begin
      new_slot = SlotW'(filled_q);
    end else begin
      new_slot = chain_slot[filled_q];
    end
  end

  assign out_free = !out_valid_o || !out_stall_i;
  assign advance  = (state_q == ST_UPDATE) && out_free;

  assign ctl.lookup = (state_q == ST_LOOKUP);
  assign ctl.update = advance;
  assign ctl.miss   = !hit_w;

  assign chain_page[0]          = req_page_q;
  assign chain_slot[0]          = new_slot;
  assign shift_chain[MAX_FRAMES] = 1'b0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign filled_vec[g] = (32'(filled_q) > g);
    lpfr_cell #(
      .PageW(PAGE_BITS),
      .SlotW(SlotW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .filled_i   (filled_vec[g]),
      .key_i      (req_page_q),
      .prev_page_i(chain_page[g]),
      .prev_slot_i(chain_slot[g]),
      .shift_in_i (shift_chain[g+1]),
      .shift_o    (shift_chain[g]),
      .match_o    (match_vec[g]),
      .page_o     (chain_page[g+1]),
      .slot_o     (chain_slot[g+1])
    );
  end

  assign evict_ext = ExtW'(victim_page);
  assign slot_ext  = SlotExtW'(new_slot);
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      filled_q        <= '0;
      cfg_q           <= CfgReset;
      req_page_q      <= '0;
      out_valid_o     <= 1'b0;
      hit_o           <= 1'b0;
      slot_o          <= '0;
      evicted_valid_o <= 1'b0;
      evicted_page_o  <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_valid_o && !out_stall_i && !advance) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_page_q <= PAGE_BITS'(page_ext);
            state_q    <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            hit_o           <= hit_w;
            slot_o          <= PortSlotW'(slot_ext);
            evicted_valid_o <= !hit_w && !can_fill;
            evicted_page_o  <= (!hit_w && !can_fill) ? PortPageW'(evict_ext) : '0;
            if (!hit_w && can_fill) begin
              filled_q <= filled_q + CntW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(filled_q) <= MAX_FRAMES)
    else $error("fill count beyond frame count");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE |-> $onehot0(match_vec))
    else $error("page resident in more than one cell");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> !hit_o)
    else $error("eviction reported on a hit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in flight");

  a_fill_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && hit_w |=> filled_q == $past(filled_q))
    else $error("fill count moved on a hit");
`endif

endmodule

### sv/lpfr_cell.sv
// One recency cell: holds a page and its slot, shifts toward the LRU end.
`timescale 1ns / 1ps
module lpfr_cell
  import lpfr_pkg::*;
#(
  parameter int unsigned PageW = 16,
  parameter int unsigned SlotW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpfr_ctl_t        ctl_i,
  input  logic             filled_i,
  input  logic [PageW-1:0] key_i,
  input  logic [PageW-1:0] prev_page_i,
  input  logic [SlotW-1:0] prev_slot_i,
  input  logic             shift_in_i,
  output logic             shift_o,
  output logic             match_o,
  output logic [PageW-1:0] page_o,
  output logic [SlotW-1:0] slot_o
);

  logic [PageW-1:0] page_q;
  logic [SlotW-1:0] slot_q;
  logic             match_q;

  // shift_o is high for this cell and every more recent one up to the hit
  assign shift_o = match_q | shift_in_i;
  assign match_o = match_q;
  assign page_o  = page_q;
  assign slot_o  = slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.lookup) begin
      match_q <= filled_i && (page_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.update && (ctl_i.miss || shift_o)) begin
      page_q <= prev_page_i;
      slot_q <= prev_slot_i;
    end
  end

endmodule
